/* hw/rtl/jmss_pkg.sv */
// ----------------------------------------------------------------------------
// jmss_pkg: joint motion safety supervisor definitions
// Field widths, result codes and the per-lane result type shared by the
// lane, merge and top-level modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jmss_pkg;

    // field widths
    localparam int ANGLE_W  = 17;
    localparam int TORQUE_W = 16;
    localparam int TIME_W   = 32;
    localparam int TOL_W    = 17;
    localparam int ERR_W    = 18;   // |angle - target|, one spare bit
    localparam int STATUS_W = 2;
    localparam int JOINT_W  = 3;
    localparam int CFG_W    = 32;   // widest register (motion timeout)
    localparam int OUT_W    = 8;    // status, fault_joint, armed, stop_all, padded

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERTORQ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;

    // item function codes
    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // configuration reset values
    localparam logic signed [TORQUE_W-1:0] TORQUE_LIMIT_RST = 16'sd10000;
    localparam logic [TIME_W-1:0]          MOTION_TIMEOUT_RST = 32'd5000;
    localparam logic [TOL_W-1:0]           ANGLE_TOL_RST = 17'd150;

    // what one lane finds for its joint
    typedef struct packed {
        logic             over_trq;  // torque strictly above limit
        logic             out_tol;   // error strictly above tolerance
        logic [ERR_W-1:0] err;       // absolute angle error
    } lane_res_t;

    // merged decision over all lanes
    typedef struct packed {
        logic               over_trq;   // some joint over torque
        logic [JOINT_W-1:0] trq_joint;  // lowest such joint, 1-based
        logic               all_tol;    // every joint within tolerance
        logic [JOINT_W-1:0] max_joint;  // joint of largest error, first on tie
    } merge_res_t;

endpackage : jmss_pkg

`default_nettype wire

/* hw/rtl/jmss_lane.sv */
// ----------------------------------------------------------------------------
// jmss_lane: per-joint check lane
// Compares one joint's torque with its limit and its angle error with the
// tolerance; reports the absolute error for the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jmss_lane (
    input  wire logic signed [jmss_pkg::ANGLE_W-1:0]  angle,
    input  wire logic signed [jmss_pkg::ANGLE_W-1:0]  target,
    input  wire logic signed [jmss_pkg::TORQUE_W-1:0] torque,
    input  wire logic signed [jmss_pkg::TORQUE_W-1:0] limit,
    input  wire logic        [jmss_pkg::TOL_W-1:0]    tolerance,
    output jmss_pkg::lane_res_t                        res
);
    import jmss_pkg::*;

    logic signed [ERR_W-1:0] diff;
    logic        [ERR_W-1:0] abs_err;

    // signed difference, one bit wider than the angles
    assign diff    = ERR_W'(angle) - ERR_W'(target);
    assign abs_err = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);

    assign res.over_trq = (torque > limit);
    assign res.out_tol  = (abs_err > ERR_W'(tolerance));
    assign res.err      = abs_err;

endmodule : jmss_lane

`default_nettype wire

/* hw/rtl/jmss_merge.sv */
// ----------------------------------------------------------------------------
// jmss_merge: lane merging stage
// Picks the lowest over-torque joint, checks that all joints are within
// tolerance and finds the joint with the largest error (first on a tie).
// ----------------------------------------------------------------------------
`default_nettype none

module jmss_merge #(
    parameter int JOINTS = 4
) (
    input  wire jmss_pkg::lane_res_t lanes [JOINTS],
    output jmss_pkg::merge_res_t     res
);
    import jmss_pkg::*;

    always_comb begin
        logic [ERR_W-1:0] best;
        res = '0;
        best = '0;
        res.all_tol = 1'b1;
        // priority pick, scanned from the top so the lowest joint wins
        for (int i = JOINTS - 1; i >= 0; i--) begin
            if (lanes[i].over_trq) begin
                res.over_trq  = 1'b1;
                res.trq_joint = JOINT_W'(i + 1);
            end
        end
        // tolerance and largest-error chain
        for (int i = 0; i < JOINTS; i++) begin
            if (lanes[i].out_tol) begin
                res.all_tol = 1'b0;
            end
            if (lanes[i].err > best) begin
                best          = lanes[i].err;
                res.max_joint = JOINT_W'(i + 1);
            end
        end
    end

endmodule : jmss_merge

`default_nettype wire

/* hw/rtl/joint_motion_safety_supervisor.sv */
// ----------------------------------------------------------------------------
// joint_motion_safety_supervisor: multi-joint move supervisor
// Holds targets and start time of a move, checks torque, angle error and
// elapsed time on each check transaction and raises alarms.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per sample. s_tuser is the function
//   (set targets or check), s_tdata carries time, angles and torques.
//   m_ channel: one result transaction per input transaction, in order.
//   cfg_we/cfg_index/cfg_wdata: torque limits, motion timeout and angle
//   tolerance; write only while the block is idle.
// Result: held in the output register, or in the skid while the output stalls.
// Throughput: one transaction per cycle while s_tready is high. Per-joint
//   compares run in parallel lanes and merge in the same cycle that updates
//   the armed state, so the next item sees that state without waiting.
// Stall: a two-entry output buffer (output register plus skid register)
//   absorbs one extra result; s_tready drops only while the skid is full.
// Reset: aresetn (synchronous, active low) disarms the supervisor, clears
//   targets and start time, empties the output buffer and restores all
//   configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_motion_safety_supervisor #(
    parameter int JOINTS = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: now_ms, angle_0..angle_N-1, torque_0..torque_N-1, zero pad
    input  wire logic [((32 + JOINTS*33 + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: func
    input  wire logic [0:0]                    s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: status[1:0], fault_joint[4:2], armed[5], stop_all[6], zero pad
    output logic [jmss_pkg::OUT_W-1:0]         m_tdata,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [$clog2(JOINTS + 2)-1:0] cfg_index,
    input  wire logic [jmss_pkg::CFG_W-1:0]    cfg_wdata
);
    import jmss_pkg::*;

    localparam int CFG_IDX_W = $clog2(JOINTS + 2);
    localparam int TRQ_BASE  = TIME_W + JOINTS * ANGLE_W;

    // configuration registers
    logic signed [TORQUE_W-1:0] limit_reg [JOINTS];
    logic        [TIME_W-1:0]   timeout_reg;
    logic        [TOL_W-1:0]    tol_reg;

    // move state
    logic signed [ANGLE_W-1:0]  target_reg [JOINTS];
    logic        [TIME_W-1:0]   start_reg;
    logic                       active_reg;
    logic                       active_next;

    // output buffer
    logic [OUT_W-1:0] out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    logic               accept, take;
    logic               func;
    logic [TIME_W-1:0]  now_ms, elapsed;
    logic               timed_out;
    lane_res_t          lane_res [JOINTS];
    merge_res_t         mres;

    logic [STATUS_W-1:0] r_status;
    logic [JOINT_W-1:0]  r_joint;
    logic                r_stop;
    logic [OUT_W-1:0]    result;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign take     = m_tvalid & m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign func   = s_tuser[0];
    assign now_ms = s_tdata[TIME_W-1:0];

    // per-joint lanes
    for (genvar g = 0; g < JOINTS; g++) begin : g_lane
        jmss_lane u_lane (
            .angle     (s_tdata[TIME_W + g*ANGLE_W +: ANGLE_W]),
            .target    (target_reg[g]),
            .torque    (s_tdata[TRQ_BASE + g*TORQUE_W +: TORQUE_W]),
            .limit     (limit_reg[g]),
            .tolerance (tol_reg),
            .res       (lane_res[g])
        );
    end

    // merge of lane findings
    jmss_merge #(.JOINTS(JOINTS)) u_merge (
        .lanes (lane_res),
        .res   (mres)
    );

    // wrapping elapsed time against timeout
    assign elapsed   = now_ms - start_reg;
    assign timed_out = (elapsed > timeout_reg);

    // decision for this transaction
    always_comb begin
        r_status    = ST_OK;
        r_joint     = '0;
        r_stop      = 1'b0;
        active_next = active_reg;
        if (func == FUNC_SET) begin
            active_next = 1'b1;
        end else if (active_reg) begin
            if (mres.over_trq) begin
                r_status    = ST_OVERTORQ;
                r_joint     = mres.trq_joint;
                r_stop      = 1'b1;
                active_next = 1'b0;
            end else if (mres.all_tol) begin
                active_next = 1'b0;
            end else if (timed_out) begin
                r_status    = ST_TIMEOUT;
                r_joint     = mres.max_joint;
                r_stop      = 1'b1;
                active_next = 1'b0;
            end
        end
    end

    assign result = OUT_W'({r_stop, active_next, r_joint, r_status});

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < JOINTS; i++) begin
                limit_reg[i] <= TORQUE_LIMIT_RST;
            end
            timeout_reg <= MOTION_TIMEOUT_RST;
            tol_reg     <= ANGLE_TOL_RST;
        end else if (cfg_we) begin
            for (int i = 0; i < JOINTS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    limit_reg[i] <= cfg_wdata[TORQUE_W-1:0];
                end
            end
            if (cfg_index == CFG_IDX_W'(JOINTS)) begin
                timeout_reg <= cfg_wdata[TIME_W-1:0];
            end
            if (cfg_index == CFG_IDX_W'(JOINTS + 1)) begin
                tol_reg <= cfg_wdata[TOL_W-1:0];
            end
        end
    end

    // move state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < JOINTS; i++) begin
                target_reg[i] <= '0;
            end
            start_reg  <= '0;
            active_reg <= 1'b0;
        end else if (accept) begin
            active_reg <= active_next;
            if (func == FUNC_SET) begin
                for (int i = 0; i < JOINTS; i++) begin
                    target_reg[i] <= s_tdata[TIME_W + i*ANGLE_W +: ANGLE_W];
                end
                start_reg <= now_ms;
            end
        end
    end

    // output register plus skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
                if (accept) begin
                    out_reg <= result;
                end
            end
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end else begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_stalled_goes_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result accepted under stall was not kept in skid");

    a_alarm_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && r_stop) |=> !active_reg)
        else $error("alarm did not disarm the supervisor");

    a_set_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_SET) |=> (active_reg && start_reg == $past(now_ms)))
        else $error("set transaction did not arm the move");

endmodule : joint_motion_safety_supervisor

`default_nettype wire

/* tb/tb_joint_motion_safety_supervisor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joint_motion_safety_supervisor: self-checking bench for the supervisor
// Drives set-target and check transactions into the stream input and keeps a
// cycle-free copy of the supervisor state: targets, start time, armed flag and
// the configuration registers. Each result transaction is compared field by
// field with the oldest predicted result. Directed tests cover the torque,
// tolerance and timeout edges and the register extremes. Random phases follow
// with new register settings and random gaps and stalls on both sides.
// ----------------------------------------------------------------------------

module tb_joint_motion_safety_supervisor;
    import jmss_pkg::*;

    localparam int JOINTS   = 4;
    localparam int S_W      = ((32 + JOINTS*33 + 7) / 8) * 8;
    localparam int IDX_W    = $clog2(JOINTS + 2);
    localparam int LIMIT    = 500000;
    localparam int ANGLE_LO = -36000;
    localparam int ANGLE_HI = 36000;
    localparam int TRQ_LO   = -32768;
    localparam int TRQ_HI   = 32767;

    // register indexes
    localparam int REG_TORQUE_LIMIT_0 = 0;
    localparam int REG_MOTION_TIMEOUT = 4;
    localparam int REG_ANGLE_TOL      = 5;
    localparam int REG_UNUSED_LO      = 6;
    localparam int REG_UNUSED_HI      = 7;

    // one sample, packed exactly as s_tdata without the pad
    typedef struct packed {
        logic [JOINTS-1:0][TORQUE_W-1:0] torque;
        logic [JOINTS-1:0][ANGLE_W-1:0]  angle;
        logic [TIME_W-1:0]               now_ms;
    } sample_t;

    // one result, packed as m_tdata[6:0]
    typedef struct packed {
        logic                stop_all;
        logic                armed;
        logic [JOINT_W-1:0]  fault_joint;
        logic [STATUS_W-1:0] status;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_W-1:0]    s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // shadow of the supervisor
    logic signed [TORQUE_W-1:0]     limit_q [JOINTS];
    logic [TIME_W-1:0]              timeout_q;
    logic [TOL_W-1:0]               tol_q;
    logic [JOINTS-1:0][ANGLE_W-1:0] target_q;
    logic [TIME_W-1:0]              move_start_q;
    logic                           armed_q;

    verdict_t pending_verdicts[$];
    verdict_t want;
    verdict_t got;
    int       errors = 0;
    int       cycle_count = 0;
    bit       sender_idles = 1'b0;
    bit       receiver_stalls = 1'b0;
    int       stall_left = 0;

    joint_motion_safety_supervisor #(.JOINTS(JOINTS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // supervisor decision for one accepted transaction, updates the shadow
    function automatic verdict_t supervise(logic func, sample_t s);
        verdict_t   r;
        int         d;
        int         worst;
        bit         all_in;
        logic [31:0] elapsed;
        r = '0;
        if (func == FUNC_SET) begin
            target_q     = s.angle;
            move_start_q = s.now_ms;
            armed_q      = 1'b1;
        end else if (armed_q) begin
            // lowest joint over its torque limit wins
            for (int i = 0; i < JOINTS; i++) begin
                if (r.status == ST_OK && $signed(s.torque[i]) > limit_q[i]) begin
                    r.status      = ST_OVERTORQ;
                    r.fault_joint = JOINT_W'(i + 1);
                end
            end
            if (r.status == ST_OK) begin
                all_in = 1'b1;
                for (int i = 0; i < JOINTS; i++) begin
                    d = int'($signed(s.angle[i])) - int'($signed(target_q[i]));
                    if (d < 0) d = -d;
                    if (d > int'(tol_q)) all_in = 1'b0;
                end
                elapsed = s.now_ms - move_start_q;
                if (all_in) begin
                    armed_q = 1'b0;
                end else if (elapsed > timeout_q) begin
                    // largest error names the joint, first one on a tie
                    r.status = ST_TIMEOUT;
                    worst = 0;
                    for (int i = 0; i < JOINTS; i++) begin
                        d = int'($signed(s.angle[i])) - int'($signed(target_q[i]));
                        if (d < 0) d = -d;
                        if (d > worst) begin
                            worst         = d;
                            r.fault_joint = JOINT_W'(i + 1);
                        end
                    end
                end
            end
            if (r.status != ST_OK) begin
                armed_q    = 1'b0;
                r.stop_all = 1'b1;
            end
        end
        r.armed = armed_q;
        return r;
    endfunction

    function automatic sample_t make_sample(logic [31:0] now, int a0, int a1, int a2,
                                            int a3, int t0, int t1, int t2, int t3);
        sample_t s;
        s.now_ms    = now;
        s.angle[0]  = a0[ANGLE_W-1:0];
        s.angle[1]  = a1[ANGLE_W-1:0];
        s.angle[2]  = a2[ANGLE_W-1:0];
        s.angle[3]  = a3[ANGLE_W-1:0];
        s.torque[0] = t0[TORQUE_W-1:0];
        s.torque[1] = t1[TORQUE_W-1:0];
        s.torque[2] = t2[TORQUE_W-1:0];
        s.torque[3] = t3[TORQUE_W-1:0];
        return s;
    endfunction

    // torque at or below the limit, or above it when one exists
    function automatic int pick_torque(int lim, bit over);
        if (over && lim < TRQ_HI)
            return lim + 1 + int'($urandom_range(0, TRQ_HI - lim - 1));
        if (over)
            return TRQ_HI;
        return TRQ_LO + int'($urandom_range(0, lim - TRQ_LO));
    endfunction

    // one input transaction, with an optional gap before it
    task automatic send_item(logic func, sample_t s);
        int gap;
        int r;
        gap = 0;
        if (sender_idles) begin
            r = $urandom_range(0, 99);
            if (r >= 92)      gap = $urandom_range(10, 40);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(s);
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(supervise(func, s));
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(int index, logic [31:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= IDX_W'(index);
        cfg_wdata <= value;
        @(posedge aclk);
        if (index < JOINTS)                  limit_q[index] = value[TORQUE_W-1:0];
        else if (index == REG_MOTION_TIMEOUT) timeout_q = value;
        else if (index == REG_ANGLE_TOL)      tol_q = value[TOL_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls, short mostly, a few long
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!receiver_stalls) begin
            m_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    stall_left <= $urandom_range(10, 40);
                    m_tready   <= 1'b0;
                end
                1, 2, 3, 4, 5: begin
                    stall_left <= $urandom_range(0, 2);
                    m_tready   <= 1'b0;
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = verdict_t'(m_tdata[6:0]);
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with none predicted, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.fault_joint !== want.fault_joint) begin
                    $display("%0t: fault_joint expected %0d actual %0d",
                             $time, want.fault_joint, got.fault_joint);
                    errors++;
                end
                if (got.armed !== want.armed) begin
                    $display("%0t: armed expected %0d actual %0d",
                             $time, want.armed, got.armed);
                    errors++;
                end
                if (got.stop_all !== want.stop_all) begin
                    $display("%0t: stop_all expected %0d actual %0d",
                             $time, want.stop_all, got.stop_all);
                    errors++;
                end
            end
        end
    end

    // check while disarmed right after reset
    task automatic test_disarmed_check();
        send_item(FUNC_CHECK, make_sample(32'd1234, 100, -100, 5, 7, 0, 0, 0, 0));
    endtask

    // torque equal to the limit, first joint over the limit, extreme torques
    task automatic test_torque_alarms();
        send_item(FUNC_SET, make_sample(32'd100, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'd200, 1000, 1000, 1000, 1000,
                                          10000, 10000, 10000, 10000));
        send_item(FUNC_CHECK, make_sample(32'd300, 0, 0, 0, 0, 0, 10001, TRQ_HI, 0));
        send_item(FUNC_CHECK, make_sample(32'd400, 0, 0, 0, 0, TRQ_HI, 0, 0, 0));
        send_item(FUNC_SET, make_sample(32'd500, 10, 20, 30, 40, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'd600, 0, 0, 0, 0,
                                          TRQ_LO, TRQ_LO, TRQ_LO, TRQ_HI));
    endtask

    // tolerance boundary, set while armed, elapsed time at and past the
    // timeout across the wrap, and ties on the largest error
    task automatic test_done_and_timeout();
        send_item(FUNC_SET, make_sample(32'hFFFF_F000, ANGLE_LO, ANGLE_HI, -1, 0,
                                        0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'hFFFF_F100, ANGLE_LO + 150, ANGLE_HI - 150,
                                          149, -150, 0, 0, 0, 0));
        send_item(FUNC_SET, make_sample(32'hFFFF_F000, ANGLE_LO, ANGLE_HI, -1, 0,
                                        0, 0, 0, 0));
        send_item(FUNC_SET, make_sample(32'hFFFF_FF00, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'hFFFF_FF00 + 32'd5000, 151, -151, 0, 0,
                                          0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'hFFFF_FF00 + 32'd5001, 151, -151, 0, 0,
                                          0, 0, 0, 0));
        send_item(FUNC_SET, make_sample(32'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'd5001, 0, 0, ANGLE_HI, ANGLE_LO,
                                          0, 0, 0, 0));
    endtask

    // extreme register values, plus writes to indexes past the list
    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_TORQUE_LIMIT_0 + 0, 32'hFFFF_8000);
        write_reg(REG_TORQUE_LIMIT_0 + 1, 32'h0000_7FFF);
        write_reg(REG_TORQUE_LIMIT_0 + 2, 32'hFFFF_FFFF);
        write_reg(REG_TORQUE_LIMIT_0 + 3, 32'h0000_0000);
        write_reg(REG_MOTION_TIMEOUT, 32'd0);
        write_reg(REG_ANGLE_TOL, 32'd0);
        write_reg(REG_UNUSED_LO, 32'hA5A5_A5A5);
        write_reg(REG_UNUSED_HI, 32'h5A5A_5A5A);
        send_item(FUNC_SET, make_sample(32'd7, 5, 5, 5, 5, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'd7, 5, 5, 5, 5, TRQ_LO, TRQ_HI, -1, 0));
        send_item(FUNC_SET, make_sample(32'd7, 5, 5, 5, 5, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'd7, 5, 5, 5, 5, TRQ_LO + 1, 0, -1, 0));
        send_item(FUNC_SET, make_sample(32'd7, 5, 5, 5, 5, 0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'd7, 6, 5, 5, 5, TRQ_LO, 0, -1, 0));
        send_item(FUNC_CHECK, make_sample(32'd8, 6, 5, 5, 5, TRQ_LO, 0, -1, 0));
        wait_idle();
        write_reg(REG_MOTION_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_ANGLE_TOL, 32'd72000);
        send_item(FUNC_SET, make_sample(32'd0, ANGLE_LO, ANGLE_LO, ANGLE_LO, ANGLE_LO,
                                        0, 0, 0, 0));
        send_item(FUNC_CHECK, make_sample(32'hFFFF_FFFF, ANGLE_HI, ANGLE_HI, ANGLE_HI,
                                          ANGLE_HI, TRQ_LO, TRQ_HI, -1, 0));
    endtask

    // random phases: new settings, then mostly set-and-check moves with noise
    task automatic test_random_moves();
        int          sent;
        int          steps;
        int          span;
        int          v;
        int          r;
        logic [31:0] value;
        logic [31:0] clock_ms;
        sample_t     tgt;
        sample_t     s;
        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            for (int j = 0; j < JOINTS; j++) begin
                r = $urandom_range(0, 9);
                if (r < 8)       value = $urandom_range(1000, 20000);
                else if (r == 8) value = ($urandom_range(0, 1) != 0) ? 32'hFFFF_8000
                                                                  : 32'h0000_7FFF;
                else             value = $urandom;
                write_reg(REG_TORQUE_LIMIT_0 + j, value);
            end
            r = $urandom_range(0, 19);
            if (r < 14)      value = $urandom_range(0, 3000);
            else if (r < 17) value = 32'd0;
            else             value = $urandom;
            write_reg(REG_MOTION_TIMEOUT, value);
            r = $urandom_range(0, 19);
            if (r < 14)      value = $urandom_range(0, 400);
            else if (r < 16) value = 32'd0;
            else if (r < 18) value = 32'd72000;
            else             value = $urandom_range(0, 72000);
            write_reg(REG_ANGLE_TOL, value);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI), $urandom);

            // first phase runs with no gaps on either side
            sender_idles    = (phase != 0) && ($urandom_range(0, 3) != 0);
            receiver_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 70) begin
                if ($urandom_range(0, 9) < 2) begin
                    // noise: any function, any field value
                    s.now_ms = $urandom;
                    for (int j = 0; j < JOINTS; j++) begin
                        v = ANGLE_LO + int'($urandom_range(0, ANGLE_HI - ANGLE_LO));
                        s.angle[j]  = v[ANGLE_W-1:0];
                        s.torque[j] = TORQUE_W'($urandom);
                    end
                    send_item(1'($urandom_range(0, 1)), s);
                    sent++;
                end else begin
                    // one move: set targets, then a run of checks
                    tgt.now_ms = $urandom;
                    for (int j = 0; j < JOINTS; j++) begin
                        v = ANGLE_LO + int'($urandom_range(0, ANGLE_HI - ANGLE_LO));
                        tgt.angle[j]  = v[ANGLE_W-1:0];
                        tgt.torque[j] = TORQUE_W'($urandom);
                    end
                    send_item(FUNC_SET, tgt);
                    sent++;
                    clock_ms = tgt.now_ms;
                    steps = $urandom_range(1, 8);
                    for (int k = 0; k < steps; k++) begin
                        clock_ms = clock_ms + $urandom_range(0, timeout_q / 3 + 20);
                        s.now_ms = clock_ms;
                        // last check tends to land within tolerance
                        span = (k == steps - 1 && $urandom_range(0, 1) != 0)
                               ? int'(tol_q) : 3 * int'(tol_q) + 50;
                        for (int j = 0; j < JOINTS; j++) begin
                            v = int'($signed(tgt.angle[j])) +
                                int'($urandom_range(0, 2 * span)) - span;
                            if (v > ANGLE_HI) v = ANGLE_HI;
                            if (v < ANGLE_LO) v = ANGLE_LO;
                            s.angle[j] = v[ANGLE_W-1:0];
                            v = pick_torque(int'(limit_q[j]), $urandom_range(0, 11) == 0);
                            s.torque[j] = v[TORQUE_W-1:0];
                        end
                        send_item(FUNC_CHECK, s);
                        sent++;
                    end
                end
            end
        end
    endtask

    // run limit
    initial begin
        while (cycle_count < LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        for (int j = 0; j < JOINTS; j++) limit_q[j] = TORQUE_LIMIT_RST;
        timeout_q    = MOTION_TIMEOUT_RST;
        tol_q        = ANGLE_TOL_RST;
        target_q     = '0;
        move_start_q = '0;
        armed_q      = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_disarmed_check();
        test_torque_alarms();
        test_done_and_timeout();
        test_register_extremes();
        test_random_moves();

        wait_idle();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
